/* rtl/core/tpsp_pkg.sv */
// ----------------------------------------------------------------------------
// Three-phase sine PWM package
// Shared constants, command and status types and the cosine table builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpsp_pkg;

   // Fixed design constants.
   localparam int PERIOD      = 500;
   localparam int DEAD_BAND   = 4;
   localparam int PAD         = DEAD_BAND + 3;
   localparam int TABLE_DEPTH = 1024;            // power of two
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int OFFSET_B    = (TABLE_DEPTH + 1) / 3;
   localparam int OFFSET_C    = (2 * TABLE_DEPTH + 1) / 3;
   localparam int COUNT_WIDTH = 32;

   // Field and register widths.
   localparam int M_W     = 18;
   localparam int RATE_W  = 20;
   localparam int RANGE_W = 16;
   localparam int CMP_W   = 9;
   localparam int COS_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam int FREQ_SCALE = 216;               // 2.16 * 100
   localparam int DEN_SCALE  = 25600;             // 256 * 100
   localparam int K_W        = M_W + 8;           // motor_freq * 216
   localparam int DEN_W      = RATE_W + 15;       // tick_rate * 25600
   localparam int PROD_W     = COUNT_WIDTH + K_W;

   localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(10000);
   localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(32768);
   localparam logic [RANGE_W-1:0] RANGE_ONE   = RANGE_W'(32768);

   // Duty arithmetic: duty = floor((BIAS + cos * range * SCALE) / (2000 * 2^30)).
   localparam int CR_W       = COS_W + RANGE_W + 1;
   localparam int NUM_W      = 52;
   localparam int DUTY_SHIFT = 30;
   localparam int V_W        = NUM_W - DUTY_SHIFT;
   localparam int DUTY_SCALE = (PERIOD - PAD) * 866;
   localparam logic [63:0] DUTY_BIAS = 64'((PERIOD + PAD) * 1000) << DUTY_SHIFT;
   localparam int DUTY_DIV    = 2000;
   localparam int RECIP_SHIFT = 34;
   localparam int RECIP_W     = 24;
   localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / DUTY_DIV;
   localparam int QE_W        = V_W + RECIP_W - RECIP_SHIFT;
   localparam int CMP_BASE    = PERIOD + 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE     = CSR_IDX_W'(1);

   // Phase selectors.
   localparam logic [1:0] PH_A = 2'd0;
   localparam logic [1:0] PH_B = 2'd1;
   localparam logic [1:0] PH_C = 2'd2;

   // Datapath operations.
   localparam logic [3:0] OP_HOLD   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_MOD    = 4'd2;
   localparam logic [3:0] OP_MULMOD = 4'd3;
   localparam logic [3:0] OP_DIV    = 4'd4;
   localparam logic [3:0] OP_ROM    = 4'd5;
   localparam logic [3:0] OP_MUL1   = 4'd6;
   localparam logic [3:0] OP_MUL2   = 4'd7;
   localparam logic [3:0] OP_RECIP  = 4'd8;
   localparam logic [3:0] OP_FIX    = 4'd9;
   localparam logic [3:0] OP_FINISH = 4'd10;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] phase;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   typedef logic signed [COS_W-1:0] cos_table_type [TABLE_DEPTH];

   // Cosine table generation, evaluated at elaboration.
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   function automatic logic [63:0] one_minus(input logic [63:0] a);
      return (a >= ONE_Q30) ? 64'd0 : ONE_Q30 - a;
   endfunction

   function automatic logic [63:0] cos_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = q30_mul(x, x);
      t  = one_minus(x2 / 132);
      t  = one_minus(q30_mul(x2 / 90, t));
      t  = one_minus(q30_mul(x2 / 56, t));
      t  = one_minus(q30_mul(x2 / 30, t));
      t  = one_minus(q30_mul(x2 / 12, t));
      return one_minus(q30_mul(x2 / 2, t));
   endfunction

   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      x2 = q30_mul(x, x);
      t  = one_minus(x2 / 110);
      t  = one_minus(q30_mul(x2 / 72, t));
      t  = one_minus(q30_mul(x2 / 42, t));
      t  = one_minus(q30_mul(x2 / 20, t));
      t  = one_minus(q30_mul(x2 / 6, t));
      return q30_mul(x, t);
   endfunction

   function automatic cos_table_type build_cos_table();
      cos_table_type tab;
      logic [63:0]   u;
      logic [63:0]   quad;
      logic [63:0]   x;
      logic [63:0]   v;
      logic [63:0]   q;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         u    = (64'(i) << 32) / TABLE_DEPTH;
         quad = (u >> 30) & 64'd3;
         x    = ((u & (ONE_Q30 - 64'd1)) * HALF_PI_Q30) >> 30;
         v    = (quad == 64'd0 || quad == 64'd2) ? cos_q30(x) : sin_q30(x);
         q    = (v + (64'd1 << 14)) >> 15;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         if (quad == 64'd1 || quad == 64'd2) begin
            tab[i] = -$signed(COS_W'(q));
         end else begin
            tab[i] = $signed(COS_W'(q));
         end
      end
      return tab;
   endfunction

endpackage

/* rtl/core/tpsp_ctrl.sv */
// ----------------------------------------------------------------------------
// Three-phase sine PWM controller
// Sequences the datapath through remainder, divide and duty steps per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tpsp_pkg::status_type   status,
   output tpsp_pkg::cmd_type      cmd
);

   localparam int ITER_W = 6;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MOD    = 4'd1;
   localparam logic [3:0] S_MULMOD = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_ROM    = 4'd4;
   localparam logic [3:0] S_MUL1   = 4'd5;
   localparam logic [3:0] S_MUL2   = 4'd6;
   localparam logic [3:0] S_RECIP  = 4'd7;
   localparam logic [3:0] S_FIX    = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [1:0]        phase_ff, phase_in;

   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      cmd.op    = tpsp_pkg::OP_HOLD;
      cmd.phase = phase_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = tpsp_pkg::OP_LOAD;
               iter_in  = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.op  = tpsp_pkg::OP_MOD;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(tpsp_pkg::COUNT_WIDTH - 1)) begin
               iter_in  = '0;
               state_in = S_MULMOD;
            end
         end
         S_MULMOD: begin
            cmd.op  = tpsp_pkg::OP_MULMOD;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(tpsp_pkg::K_W - 1)) begin
               iter_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op  = tpsp_pkg::OP_DIV;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(tpsp_pkg::IDX_W - 1)) begin
               iter_in  = '0;
               phase_in = tpsp_pkg::PH_A;
               state_in = S_ROM;
            end
         end
         S_ROM: begin
            cmd.op   = tpsp_pkg::OP_ROM;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.op   = tpsp_pkg::OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = tpsp_pkg::OP_MUL2;
            state_in = S_RECIP;
         end
         S_RECIP: begin
            cmd.op   = tpsp_pkg::OP_RECIP;
            state_in = S_FIX;
         end
         S_FIX: begin
            cmd.op = tpsp_pkg::OP_FIX;
            if (phase_ff == tpsp_pkg::PH_C) begin
               state_in = S_DONE;
            end else begin
               phase_in = phase_ff + 1'b1;
               state_in = S_ROM;
            end
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.op   = tpsp_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
         phase_ff <= tpsp_pkg::PH_A;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* rtl/core/tpsp_datapath.sv */
// ----------------------------------------------------------------------------
// Three-phase sine PWM datapath
// Serial remainder and divide, cosine ROM, duty arithmetic and tick counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tpsp_pkg::cmd_type                   cmd,
   output tpsp_pkg::status_type                status,
   input  logic [tpsp_pkg::M_W-1:0]            motor_freq_q8,
   input  logic [tpsp_pkg::RATE_W-1:0]         tick_rate_hz,
   input  logic [tpsp_pkg::RANGE_W-1:0]        range_setting,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [tpsp_pkg::CMP_W-1:0]          compare_a,
   output logic [tpsp_pkg::CMP_W-1:0]          compare_b,
   output logic [tpsp_pkg::CMP_W-1:0]          compare_c
);

   localparam tpsp_pkg::cos_table_type COS_TABLE = tpsp_pkg::build_cos_table();

   localparam int DEN_W  = tpsp_pkg::DEN_W;
   localparam int K_W    = tpsp_pkg::K_W;
   localparam int CNT_W  = tpsp_pkg::COUNT_WIDTH;
   localparam int IDX_W  = tpsp_pkg::IDX_W;
   localparam int V_W    = tpsp_pkg::V_W;
   localparam int QE_W   = tpsp_pkg::QE_W;
   localparam int NUM_W  = tpsp_pkg::NUM_W;
   localparam int CR_W   = tpsp_pkg::CR_W;
   localparam int CMP_W  = tpsp_pkg::CMP_W;
   localparam int PROD_W = tpsp_pkg::PROD_W;
   localparam int RP_W   = V_W + tpsp_pkg::RECIP_W;

   // Operand registers.
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [K_W-1:0]    kshift_ff, kshift_in;
   logic              m_nz_ff, m_nz_in;
   logic [CNT_W-1:0]  cshift_ff, cshift_in;
   logic [DEN_W-1:0]  a_ff, a_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // Duty pipeline registers.
   logic signed [tpsp_pkg::COS_W-1:0] rom_ff;
   logic signed [CR_W-1:0]            cr_ff, cr_in;
   logic [V_W-1:0]                    v_ff, v_in;
   logic [QE_W-1:0]                   qe_ff, qe_in;
   logic [CMP_W-1:0]                  cmp_a_ff, cmp_b_ff, cmp_c_ff;
   logic [CMP_W-1:0]                  cmp_in;

   // Counter and result.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PROD_W-1:0] prod_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CMP_W-1:0]  rsp_a_ff, rsp_b_ff, rsp_c_ff;

   // Step logic.
   logic [tpsp_pkg::RATE_W-1:0]  t_eff;
   logic [DEN_W:0]               mod_s;
   logic [DEN_W+1:0]             mm_s;
   logic [DEN_W+1:0]             den1_x;
   logic [DEN_W+1:0]             den2_x;
   logic [DEN_W:0]               dv_s;
   logic                         dv_ge;
   logic [IDX_W:0]               addr_sum;
   logic [IDX_W:0]               offset;
   logic [IDX_W-1:0]             rom_addr;
   logic [tpsp_pkg::RANGE_W-1:0] r_eff;
   logic signed [CR_W-1:0]       r_signed;
   logic signed [NUM_W-1:0]      num;
   logic [RP_W-1:0]              rp;
   logic [V_W-1:0]               qd;
   logic [V_W-1:0]               frac;
   logic [QE_W-1:0]              q_fix;
   logic [QE_W-1:0]              cmp_full;
   logic [CNT_W-1:0]             cnt_inc;

   assign t_eff  = (tick_rate_hz == '0) ? tpsp_pkg::RATE_W'(1) : tick_rate_hz;
   assign r_eff  = (range_setting > tpsp_pkg::RANGE_ONE) ? tpsp_pkg::RANGE_ONE
                                                         : range_setting;
   assign r_signed = $signed(CR_W'(r_eff));

   // One restoring step of count mod den.
   assign mod_s = {a_ff, cshift_ff[CNT_W-1]};

   // One interleaved step of (a * k) mod den; the sum stays below three den.
   assign den1_x = (DEN_W+2)'(den_ff);
   assign den2_x = {1'b0, den_ff, 1'b0};
   assign mm_s   = {1'b0, rem_ff, 1'b0} + (kshift_ff[K_W-1] ? (DEN_W+2)'(a_ff) : '0);

   // One restoring step of the index quotient.
   assign dv_s  = {rem_ff, 1'b0};
   assign dv_ge = dv_s >= (DEN_W+1)'(den_ff);

   // Table address for the current phase.
   always_comb begin
      case (cmd.phase)
         tpsp_pkg::PH_B: offset = (IDX_W+1)'(tpsp_pkg::OFFSET_B);
         tpsp_pkg::PH_C: offset = (IDX_W+1)'(tpsp_pkg::OFFSET_C);
         default:        offset = '0;
      endcase
   end

   assign addr_sum = (IDX_W+1)'(idx_ff) + offset;
   assign rom_addr = (addr_sum >= (IDX_W+1)'(tpsp_pkg::TABLE_DEPTH))
                     ? IDX_W'(addr_sum - (IDX_W+1)'(tpsp_pkg::TABLE_DEPTH))
                     : addr_sum[IDX_W-1:0];

   // Duty arithmetic.
   assign num  = cr_ff * $signed(NUM_W'(tpsp_pkg::DUTY_SCALE))
                 + $signed(NUM_W'(tpsp_pkg::DUTY_BIAS));
   assign rp   = RP_W'(v_ff) * RP_W'(tpsp_pkg::RECIP);
   assign qd   = V_W'(qe_ff) * V_W'(tpsp_pkg::DUTY_DIV);
   assign frac = v_ff - qd;
   assign q_fix = qe_ff + QE_W'(frac >= V_W'(tpsp_pkg::DUTY_DIV));
   assign cmp_full = QE_W'(tpsp_pkg::CMP_BASE) - q_fix;
   assign cmp_in   = cmp_full[CMP_W-1:0];

   assign cnt_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   always_comb begin
      den_in    = den_ff;
      k_in      = k_ff;
      kshift_in = kshift_ff;
      m_nz_in   = m_nz_ff;
      cshift_in = cshift_ff;
      a_in      = a_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      cr_in     = cr_ff;
      v_in      = v_ff;
      qe_in     = qe_ff;
      count_in  = count_ff;
      case (cmd.op)
         tpsp_pkg::OP_LOAD: begin
            den_in    = DEN_W'(t_eff) * DEN_W'(tpsp_pkg::DEN_SCALE);
            k_in      = K_W'(motor_freq_q8) * K_W'(tpsp_pkg::FREQ_SCALE);
            kshift_in = K_W'(motor_freq_q8) * K_W'(tpsp_pkg::FREQ_SCALE);
            m_nz_in   = motor_freq_q8 != '0;
            cshift_in = count_ff;
            a_in      = '0;
            rem_in    = '0;
            idx_in    = '0;
         end
         tpsp_pkg::OP_MOD: begin
            a_in      = (mod_s >= (DEN_W+1)'(den_ff)) ? DEN_W'(mod_s - (DEN_W+1)'(den_ff))
                                                      : DEN_W'(mod_s);
            cshift_in = {cshift_ff[CNT_W-2:0], 1'b0};
         end
         tpsp_pkg::OP_MULMOD: begin
            if (mm_s >= den2_x) begin
               rem_in = DEN_W'(mm_s - den2_x);
            end else if (mm_s >= den1_x) begin
               rem_in = DEN_W'(mm_s - den1_x);
            end else begin
               rem_in = DEN_W'(mm_s);
            end
            kshift_in = {kshift_ff[K_W-2:0], 1'b0};
         end
         tpsp_pkg::OP_DIV: begin
            rem_in = dv_ge ? DEN_W'(dv_s - (DEN_W+1)'(den_ff)) : DEN_W'(dv_s);
            idx_in = {idx_ff[IDX_W-2:0], dv_ge};
         end
         tpsp_pkg::OP_MUL1: begin
            cr_in = CR_W'(rom_ff) * r_signed;
         end
         tpsp_pkg::OP_MUL2: begin
            v_in = num[NUM_W-1] ? '0 : num[tpsp_pkg::DUTY_SHIFT +: V_W];
         end
         tpsp_pkg::OP_RECIP: begin
            qe_in = rp[tpsp_pkg::RECIP_SHIFT +: QE_W];
         end
         tpsp_pkg::OP_FINISH: begin
            // Clear once the advanced count passes den / k, written as count * k > den.
            count_in = (m_nz_ff && prod_ff > PROD_W'(den_ff)) ? '0 : cnt_inc;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (cmd.op == tpsp_pkg::OP_FINISH) | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff    <= den_in;
      k_ff      <= k_in;
      kshift_ff <= kshift_in;
      m_nz_ff   <= m_nz_in;
      cshift_ff <= cshift_in;
      a_ff      <= a_in;
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      cr_ff     <= cr_in;
      v_ff      <= v_in;
      qe_ff     <= qe_in;
      prod_ff   <= PROD_W'(cnt_inc) * PROD_W'(k_ff);
      if (cmd.op == tpsp_pkg::OP_ROM) begin
         rom_ff <= COS_TABLE[rom_addr];
      end
      if (cmd.op == tpsp_pkg::OP_FIX) begin
         case (cmd.phase)
            tpsp_pkg::PH_A: cmp_a_ff <= cmp_in;
            tpsp_pkg::PH_B: cmp_b_ff <= cmp_in;
            default:        cmp_c_ff <= cmp_in;
         endcase
      end
      if (cmd.op == tpsp_pkg::OP_FINISH) begin
         rsp_a_ff <= cmp_a_ff;
         rsp_b_ff <= cmp_b_ff;
         rsp_c_ff <= cmp_c_ff;
      end
   end

   assign status.out_busy = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign compare_a       = rsp_a_ff;
   assign compare_b       = rsp_b_ff;
   assign compare_c       = rsp_c_ff;

endmodule

/* rtl/core/three_phase_sine_pwm_modulator.sv */
// ----------------------------------------------------------------------------
// Three-phase sine PWM modulator
// Turns each PWM tick into three phase compare values from a cosine table.
// ----------------------------------------------------------------------------
// Usage: every word on the req_ channel is one PWM tick carrying the wanted
// electrical frequency in 1/256 Hz. For each tick the block returns one word
// on the rsp_ channel holding the compare values of phases A, B and C.
// The csr_ channel writes the tick rate (index 0) and the amplitude factor
// (index 1); it is always ready and should only be written while idle.
// Unknown register indexes are ignored.
// The work is serial: the counter remainder, the modular product with the
// frequency, the table index quotient and, for each phase in turn, the
// table read and the duty arithmetic through a duty path shared by the
// three phases. One tick is in progress at a time, so a new tick is taken
// only once the work on the last one is done.
// Stalls: the finished word is held in an output register. The next tick is
// accepted while that word waits; its own result is written only once the
// register has been taken, so nothing is lost when rsp_tready is low.
// Reset clears the tick counter, the output valid and loads the register
// defaults (10000 Hz tick rate, full amplitude).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_phase_sine_pwm_modulator (
   input  logic                                 clock,
   input  logic                                 reset,
   // Tick input.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,   // motor_freq_q8[17:0]
   // Compare output.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,   // compare_a[8:0],
                                                             // compare_b[17:9],
                                                             // compare_c[26:18]
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tpsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tpsp_pkg::RATE_W-1:0]          csr_data
);

   logic [tpsp_pkg::RATE_W-1:0]  tick_rate_ff, tick_rate_in;
   logic [tpsp_pkg::RANGE_W-1:0] range_ff, range_in;

   tpsp_pkg::cmd_type            cmd;
   tpsp_pkg::status_type         status;
   logic [tpsp_pkg::CMP_W-1:0]   compare_a;
   logic [tpsp_pkg::CMP_W-1:0]   compare_b;
   logic [tpsp_pkg::CMP_W-1:0]   compare_c;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      tick_rate_in = tick_rate_ff;
      range_in     = range_ff;
      if (csr_valid) begin
         case (csr_index)
            tpsp_pkg::CSR_TICK_RATE: tick_rate_in = csr_data;
            tpsp_pkg::CSR_RANGE:     range_in     = csr_data[tpsp_pkg::RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= tpsp_pkg::RATE_RESET;
         range_ff     <= tpsp_pkg::RANGE_RESET;
      end else begin
         tick_rate_ff <= tick_rate_in;
         range_ff     <= range_in;
      end
   end

   tpsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   tpsp_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .motor_freq_q8 (req_tdata[tpsp_pkg::M_W-1:0]),
      .tick_rate_hz  (tick_rate_ff),
      .range_setting (range_ff),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .compare_a     (compare_a),
      .compare_b     (compare_b),
      .compare_c     (compare_c)
   );

   // Pack the three compare values, phase A in the lowest bits.
   assign rsp_tdata = {5'b0, compare_c, compare_b, compare_a};

   // Only one tick is in flight: the input closes right after an acceptance.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("tick accepted while another is in progress");

   // A result appears only at the end of a tick's work, never straight from idle.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result presented without a tick in progress");

   // A finished result is never written over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tpsp_pkg::OP_FINISH) |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten while stalled");

endmodule
